>>> rtl/wicm_pkg.sv
// Shared types, constants and helper functions for the window interior counter.
`default_nettype none
package wicm_pkg;

  localparam int MAX_DIM    = 128;
  localparam int MAX_WINDOW = 32;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CFG_DIM_W  = 8;
  localparam int CFG_WIN_W  = 6;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = 10;
  localparam int COLSUM_W   = 5;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT   = 2'd0,
    REG_COL_COUNT   = 2'd1,
    REG_WINDOW_SIZE = 2'd2
  } cfg_reg_t;

  // Image geometry after saturation; span is the interior side (window - 2).
  typedef struct packed {
    logic [CFG_DIM_W-1:0] rows;
    logic [CFG_DIM_W-1:0] cols;
    logic [SLOT_W-1:0]    span;
  } geom_t;

  // One line-store entry: the bit history of a column and its set count.
  typedef struct packed {
    logic [MAX_WINDOW-1:0] bits;
    logic [COLSUM_W-1:0]   sum;
  } line_t;

  // Classified pixel handed from the front to the back.
  typedef struct packed {
    logic [COLSUM_W-1:0] colsum;
    logic [SLOT_W-1:0]   hslot;
    logic [SLOT_W-1:0]   lslot;
    logic                leave_ok;
    logic                row_start;
    logic                in_window;
    logic [DIM_W-1:0]    top;
    logic [DIM_W-1:0]    left;
    logic                last;
  } hitem_t;

  function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [CFG_DIM_W-1:0] r;
    r = v;
    if (v < CFG_DIM_W'(3)) r = CFG_DIM_W'(3);
    else if (v > CFG_DIM_W'(MAX_DIM)) r = CFG_DIM_W'(MAX_DIM);
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] clamp_span(input logic [CFG_WIN_W-1:0] v);
    logic [CFG_WIN_W-1:0] k;
    k = v;
    if (v < CFG_WIN_W'(3)) k = CFG_WIN_W'(3);
    else if (v > CFG_WIN_W'(MAX_WINDOW)) k = CFG_WIN_W'(MAX_WINDOW);
    return SLOT_W'(k - CFG_WIN_W'(2));
  endfunction

endpackage
`default_nettype wire

>>> rtl/wicm_front.sv
// Front end: raster position, classification and the per-column line store.
`default_nettype none
module wicm_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic            pixel_set,
  input  wire logic            last_pixel,
  input  wire wicm_pkg::geom_t geom,
  output logic                 busy,
  output logic                 push,
  output wicm_pkg::hitem_t     item
);

  logic [wicm_pkg::DIM_W-1:0]     cur_row;
  logic [wicm_pkg::DIM_W-1:0]     cur_col;
  logic [wicm_pkg::CFG_DIM_W-1:0] col_inc;
  logic [wicm_pkg::CFG_DIM_W-1:0] row_inc;
  logic                           row_ok;
  logic                           col_ok;
  logic                           row_fit;
  logic                           col_fit;
  logic [wicm_pkg::DIM_W-1:0]     top;
  logic [wicm_pkg::DIM_W-1:0]     left;

  // Stage A registers
  logic                           a_valid;
  logic                           a_bit;
  logic [wicm_pkg::DIM_W-1:0]     a_col;
  logic [wicm_pkg::SLOT_W-1:0]    a_vslot;
  logic [wicm_pkg::SLOT_W-1:0]    a_lslot;
  logic                           a_vleave;
  logic                           a_rowzero;
  wicm_pkg::hitem_t               a_item;
  wicm_pkg::line_t                rd_q;
  logic                           vld_q;

  // Line store, one row per image column
  wicm_pkg::line_t                mem [wicm_pkg::MAX_DIM];
  logic [wicm_pkg::MAX_DIM-1:0]   line_vld;
  wicm_pkg::line_t                old_line;
  wicm_pkg::line_t                wr_line;
  logic                           leaving;

  assign col_inc = {1'b0, cur_col} + wicm_pkg::CFG_DIM_W'(1);
  assign row_inc = {1'b0, cur_row} + wicm_pkg::CFG_DIM_W'(1);
  assign row_ok  = {1'b0, cur_row} >= {2'b0, geom.span};
  assign col_ok  = {1'b0, cur_col} >= {2'b0, geom.span};
  assign row_fit = ({2'b0, cur_row} + 9'd2) <= {1'b0, geom.rows};
  assign col_fit = ({2'b0, cur_col} + 9'd2) <= {1'b0, geom.cols};
  assign top     = cur_row - {2'b0, geom.span};
  assign left    = cur_col - {2'b0, geom.span};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (accept) begin
      if (last_pixel) begin
        cur_row <= '0;
        cur_col <= '0;
      end else if (col_inc >= geom.cols) begin
        cur_col <= '0;
        cur_row <= (row_inc >= geom.rows) ? '0 : row_inc[wicm_pkg::DIM_W-1:0];
      end else begin
        cur_col <= col_inc[wicm_pkg::DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_bit            <= pixel_set;
      a_col            <= cur_col;
      a_vslot          <= cur_row[wicm_pkg::SLOT_W-1:0];
      a_lslot          <= top[wicm_pkg::SLOT_W-1:0];
      a_vleave         <= row_ok;
      a_rowzero        <= (cur_row == '0);
      vld_q            <= line_vld[cur_col];
      a_item.colsum    <= '0;
      a_item.hslot     <= cur_col[wicm_pkg::SLOT_W-1:0];
      a_item.lslot     <= left[wicm_pkg::SLOT_W-1:0];
      a_item.leave_ok  <= col_ok;
      a_item.row_start <= (cur_col == '0);
      a_item.in_window <= row_ok & col_ok & row_fit & col_fit;
      a_item.top       <= top;
      a_item.left      <= left;
      a_item.last      <= last_pixel;
    end
  end

  // Read at acceptance, written back next cycle; in an image a column recurs
  // no sooner than two pixels on, so the read never overlaps a pending write.
  always_ff @(posedge clk) begin
    if (accept) rd_q <= mem[cur_col];
    if (a_valid) mem[a_col] <= wr_line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_vld <= '0;
    end else if (a_valid) begin
      line_vld[a_col] <= 1'b1;
    end
  end

  // A column on row zero starts from an empty history.
  always_comb begin
    old_line     = (vld_q && !a_rowzero) ? rd_q : '0;
    leaving      = a_vleave & old_line.bits[a_lslot];
    wr_line      = old_line;
    wr_line.bits[a_vslot] = a_bit;
    wr_line.sum  = old_line.sum - wicm_pkg::COLSUM_W'(leaving)
                   + wicm_pkg::COLSUM_W'(a_bit);
    item         = a_item;
    item.colsum  = wr_line.sum;
  end

  assign push = a_valid;
  assign busy = a_valid;

endmodule
`default_nettype wire

>>> rtl/wicm_fifo.sv
// Short queue of classified pixels between the front and the back.
`default_nettype none
module wicm_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire wicm_pkg::hitem_t              push_item,
  input  wire logic                          pop,
  output wicm_pkg::hitem_t                   head,
  output logic                               empty,
  output logic [wicm_pkg::FIFO_CNT_W-1:0]    count
);

  wicm_pkg::hitem_t                entries [wicm_pkg::FIFO_DEPTH];
  logic [wicm_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [wicm_pkg::FIFO_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + wicm_pkg::FIFO_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + wicm_pkg::FIFO_PTR_W'(1);
      if (push && !pop) count <= count + wicm_pkg::FIFO_CNT_W'(1);
      else if (pop && !push) count <= count - wicm_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);

endmodule
`default_nettype wire

>>> rtl/wicm_back.sv
// Back end: horizontal running sum, best tracking and the result register.
`default_nettype none
module wicm_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         head_valid,
  input  wire wicm_pkg::hitem_t             head,
  output logic                              take,
  input  wire logic                         pop,
  output logic                              empty,
  output logic [wicm_pkg::COUNT_W-1:0]      best_count,
  output logic [wicm_pkg::DIM_W-1:0]        best_row,
  output logic [wicm_pkg::DIM_W-1:0]        best_col
);

  logic [wicm_pkg::COLSUM_W-1:0]   hh [wicm_pkg::MAX_WINDOW];
  logic [wicm_pkg::MAX_WINDOW-1:0] hv;
  logic [wicm_pkg::COUNT_W-1:0]    running_sum;
  logic [wicm_pkg::COUNT_W-1:0]    best_so_far;
  logic [wicm_pkg::DIM_W-1:0]      best_top;
  logic [wicm_pkg::DIM_W-1:0]      best_left;
  logic                            out_valid;

  logic [wicm_pkg::COUNT_W-1:0]    base;
  logic [wicm_pkg::COLSUM_W-1:0]   hleave;
  logic [wicm_pkg::COUNT_W-1:0]    running_sum_next;
  logic                            better;
  logic [wicm_pkg::COUNT_W-1:0]    best_so_far_next;
  logic [wicm_pkg::DIM_W-1:0]      best_top_next;
  logic [wicm_pkg::DIM_W-1:0]      best_left_next;

  // Hold a last pixel back while an untaken result still occupies the output.
  assign take = head_valid && (!head.last || !out_valid || pop);

  always_comb begin
    base             = head.row_start ? '0 : running_sum;
    hleave           = (head.leave_ok && !head.row_start && hv[head.lslot]) ?
                       hh[head.lslot] : '0;
    running_sum_next = base - wicm_pkg::COUNT_W'(hleave)
                       + wicm_pkg::COUNT_W'(head.colsum);
    better           = head.in_window && (running_sum_next > best_so_far);
    best_so_far_next = better ? running_sum_next : best_so_far;
    best_top_next    = better ? head.top : best_top;
    best_left_next   = better ? head.left : best_left;
  end

  always_ff @(posedge clk) begin
    if (take) hh[head.hslot] <= head.colsum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv          <= '0;
      running_sum <= '0;
      best_so_far <= '0;
      best_top    <= '0;
      best_left   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        hv <= (head.row_start ? '0 : hv)
              | (wicm_pkg::MAX_WINDOW'(1) << head.hslot);
        if (head.last) begin
          running_sum <= '0;
          best_so_far <= '0;
          best_top    <= '0;
          best_left   <= '0;
        end else begin
          running_sum <= running_sum_next;
          best_so_far <= best_so_far_next;
          best_top    <= best_top_next;
          best_left   <= best_left_next;
        end
      end
      if (take && head.last) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && head.last) begin
      best_count <= best_so_far_next;
      best_row   <= best_top_next;
      best_col   <= best_left_next;
    end
  end

  assign empty = !out_valid;

endmodule
`default_nettype wire

>>> rtl/window_interior_count_max.sv
// Top level of the sliding-window interior counter with best-corner tracking.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   pixels   | push / full           | pixel_set, last_pixel
//   results  | pop / empty           | best_count, best_row, best_col
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle, sustained while no untaken result holds up the back
// end; full rises only when the pixel queue and the line-store stage
// together hold four transactions. A last pixel passes the line-store stage
// and the pixel queue into the result registers, behind any untaken result.
// Reset clears position, sums, best and the line-store valid bits at once;
// there is no clearing pass, so pixels are taken once reset is released.
// The per-column line store is read and written back once per pixel; that
// single read-modify-write sets the one-pixel-per-cycle figure.
`default_nettype none
module window_interior_count_max (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               pixel_set,
  input  wire logic                               last_pixel,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [wicm_pkg::COUNT_W-1:0]            best_count,
  output logic [wicm_pkg::DIM_W-1:0]              best_row,
  output logic [wicm_pkg::DIM_W-1:0]              best_col,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [wicm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wicm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [wicm_pkg::CFG_DIM_W-1:0]  row_count;
  logic [wicm_pkg::CFG_DIM_W-1:0]  col_count;
  logic [wicm_pkg::CFG_WIN_W-1:0]  window_size;
  wicm_pkg::geom_t                 geom;

  logic                            accept;
  logic                            front_busy;
  logic                            q_push;
  wicm_pkg::hitem_t                q_item;
  wicm_pkg::hitem_t                q_head;
  logic                            q_empty;
  logic [wicm_pkg::FIFO_CNT_W-1:0] q_count;
  logic                            q_take;

  // Configuration: always ready; write only while no pixel is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= wicm_pkg::CFG_DIM_W'(wicm_pkg::MAX_DIM);
      col_count   <= wicm_pkg::CFG_DIM_W'(wicm_pkg::MAX_DIM);
      window_size <= wicm_pkg::CFG_WIN_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wicm_pkg::REG_ROW_COUNT:   row_count   <= cfg_data;
        wicm_pkg::REG_COL_COUNT:   col_count   <= cfg_data;
        wicm_pkg::REG_WINDOW_SIZE: window_size <= cfg_data[wicm_pkg::CFG_WIN_W-1:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // Saturate the registers to their legal ranges before use.
  always_comb begin
    geom.rows = wicm_pkg::clamp_dim(row_count);
    geom.cols = wicm_pkg::clamp_dim(col_count);
    geom.span = wicm_pkg::clamp_span(window_size);
  end

  // Reserve a queue slot for every pixel still in the line-store stage.
  assign full = ({1'b0, q_count} + {{wicm_pkg::FIFO_CNT_W{1'b0}}, front_busy})
                >= (wicm_pkg::FIFO_CNT_W + 1)'(wicm_pkg::FIFO_DEPTH);
  assign accept = push && !full;

  wicm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pixel_set  (pixel_set),
    .last_pixel (last_pixel),
    .geom       (geom),
    .busy       (front_busy),
    .push       (q_push),
    .item       (q_item)
  );

  wicm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_take),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  wicm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!q_empty),
    .head       (q_head),
    .take       (q_take),
    .pop        (pop),
    .empty      (empty),
    .best_count (best_count),
    .best_row   (best_row),
    .best_col   (best_col)
  );

endmodule
`default_nettype wire

>>> rtl/wicm_checker.sv
// Port-level checks for the window interior counter, bound to the top level.
`default_nettype none
module wicm_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          full,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [wicm_pkg::COUNT_W-1:0]  best_count,
  input wire logic [wicm_pkg::DIM_W-1:0]    best_row,
  input wire logic [wicm_pkg::DIM_W-1:0]    best_col
);

  // Leave reset with nothing to deliver and room for pixels.
  a_reset_state: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not idle after reset");

  // A zero count never moves the corner away from the origin.
  a_zero_corner: assert property (@(posedge clk) disable iff (rst)
    (!empty && best_count == '0) |-> (best_row == '0 && best_col == '0))
    else $error("corner set for a zero count");

  // A reported corner leaves room for the smallest window inside the largest image.
  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (best_row <= wicm_pkg::DIM_W'(wicm_pkg::MAX_DIM - 3)
                && best_col <= wicm_pkg::DIM_W'(wicm_pkg::MAX_DIM - 3)))
    else $error("corner outside any possible window");

  // Hold a waiting result until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(best_count)
                          && $stable(best_row) && $stable(best_col)))
    else $error("result changed or dropped before pop");

endmodule

bind window_interior_count_max wicm_checker u_checker (.*);
`default_nettype wire

>>> tb/sv/wicm_best_board_pkg.sv
// Scoreboard class: predicts the best window interior count and corner per image and checks it.
package wicm_best_board_pkg;
  import wicm_pkg::*;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   col;
  } best_window_t;

  class best_window_board;
    logic [CFG_DIM_W-1:0] rows_reg;
    logic [CFG_DIM_W-1:0] cols_reg;
    logic [CFG_WIN_W-1:0] window_reg;

    // Per column: bit history of recent rows and their set count.
    bit [MAX_WINDOW-1:0]  column_bits [MAX_DIM];
    int unsigned          column_count [MAX_DIM];
    // Column counts of recent columns within the current row.
    int unsigned          strip_count [MAX_WINDOW];
    int unsigned          interior_sum;
    int unsigned          best_sum;
    int unsigned          best_top;
    int unsigned          best_left;
    int unsigned          row_pos;
    int unsigned          col_pos;

    best_window_t         expected_best [$];
    int unsigned          mismatches;
    int unsigned          results_checked;
    int unsigned          peak_count;

    function new();
      rows_reg     = CFG_DIM_W'(MAX_DIM);
      cols_reg     = CFG_DIM_W'(MAX_DIM);
      window_reg   = CFG_WIN_W'(3);
      interior_sum = 0;
      best_sum     = 0;
      best_top     = 0;
      best_left    = 0;
      row_pos      = 0;
      col_pos      = 0;
      foreach (column_bits[c]) begin
        column_bits[c]  = '0;
        column_count[c] = 0;
      end
      foreach (strip_count[s]) strip_count[s] = 0;
    endfunction

    function int unsigned saturate(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned image_rows();
      return saturate(rows_reg, 3, MAX_DIM);
    endfunction

    function int unsigned image_cols();
      return saturate(cols_reg, 3, MAX_DIM);
    endfunction

    function int unsigned frame_pixels();
      return image_rows() * image_cols();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_ROW_COUNT:   rows_reg = data;
        REG_COL_COUNT:   cols_reg = data;
        REG_WINDOW_SIZE: window_reg = data[CFG_WIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the prediction by one accepted pixel.
    function void note_pixel(bit px, bit last);
      int unsigned rows, cols, span, i, j, leaving;
      rows = image_rows();
      cols = image_cols();
      span = saturate(window_reg, 3, MAX_WINDOW) - 2;
      i    = row_pos % MAX_DIM;
      j    = col_pos % MAX_DIM;

      if (i == 0) begin
        column_bits[j]  = '0;
        column_count[j] = 0;
      end
      leaving = 0;
      if (i >= span) leaving = column_bits[j][(i + MAX_WINDOW - span) % MAX_WINDOW];
      column_bits[j][i % MAX_WINDOW] = px;
      column_count[j] = column_count[j] - leaving + px;

      if (j == 0) begin
        foreach (strip_count[s]) strip_count[s] = 0;
        interior_sum = 0;
      end
      leaving = 0;
      if (j >= span) leaving = strip_count[(j + MAX_WINDOW - span) % MAX_WINDOW];
      strip_count[j % MAX_WINDOW] = column_count[j];
      interior_sum = interior_sum - leaving + column_count[j];

      if (i >= span && j >= span && i + 2 <= rows && j + 2 <= cols &&
          interior_sum > best_sum) begin
        best_sum  = interior_sum;
        best_top  = i - span;
        best_left = j - span;
      end

      col_pos = j + 1;
      if (col_pos >= cols) begin
        col_pos = 0;
        row_pos = i + 1;
        if (row_pos >= rows) row_pos = 0;
      end

      if (last) begin
        expected_best.push_back('{COUNT_W'(best_sum), DIM_W'(best_top), DIM_W'(best_left)});
        best_sum     = 0;
        best_top     = 0;
        best_left    = 0;
        row_pos      = 0;
        col_pos      = 0;
        interior_sum = 0;
      end
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
      mismatches++;
      if (mismatches <= 20)
        $display("mismatch at result %0d: %s got %0d, expected %0d",
                 results_checked, what, got, want);
    endfunction

    function void check_result(logic [COUNT_W-1:0] count, logic [DIM_W-1:0] row,
                               logic [DIM_W-1:0] col);
      best_window_t want;
      if (expected_best.size() == 0) begin
        report("unrequested result, best_count", count, 0);
        return;
      end
      want = expected_best.pop_front();
      results_checked++;
      if (count !== want.count) report("best_count", count, want.count);
      if (row !== want.row) report("best_row", row, want.row);
      if (col !== want.col) report("best_col", col, want.col);
      if (want.count > peak_count) peak_count = want.count;
    endfunction
  endclass

endpackage

>>> tb/sv/testbench.sv
// Top-level testbench for the sliding-window interior counter with best-corner tracking.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wicm_pkg::*;
  import wicm_best_board_pkg::*;

  localparam int unsigned PIXEL_TARGET  = 1850;
  localparam int unsigned IMAGE_FLOOR   = 40;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  // Allow a wide settling margin once the prediction queue is dry.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic                  pixel_set = 1'b0;
  logic                  last_pixel = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [COUNT_W-1:0]    best_count;
  logic [DIM_W-1:0]      best_row;
  logic [DIM_W-1:0]      best_col;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  best_window_board      board;
  int unsigned           pixels_sent = 0;
  int unsigned           images_sent = 0;
  int unsigned           cycle_count = 0;
  bit                    push_steady = 1'b1;

  window_interior_count_max u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pixel_set  (pixel_set),
    .last_pixel (last_pixel),
    .empty      (empty),
    .pop        (pop),
    .best_count (best_count),
    .best_row   (best_row),
    .best_col   (best_col),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog: abandon the run after CYCLE_LIMIT, as when the handshakes stop moving.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Check every result transaction against the oldest prediction. Sampled on the
  // rising edge, so the values seen are those held through the previous cycle.
  always @(posedge clk) begin
    if (!rst && pop && !empty) board.check_result(best_count, best_row, best_col);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Share of set pixels in an image: blank and solid images, else a random mix.
  function automatic int unsigned pick_density();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return 100;
    return $urandom_range(5, 95);
  endfunction

  // Small image side, occasionally below the legal floor so that it saturates.
  function automatic int unsigned small_dim();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, 8);
  endfunction

  // Drop push over an idle stretch; scramble the payload meanwhile as it should be ignored.
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      push       = 1'b0;
      pixel_set  = 1'($urandom);
      last_pixel = 1'($urandom);
    end
  endtask

  // Offer one pixel and hold it until the block takes the transaction.
  task automatic send_pixel(bit px, bit last);
    @(negedge clk);
    push       = 1'b1;
    pixel_set  = px;
    last_pixel = last;
    do @(posedge clk); while (full);
    board.note_pixel(px, last);
    pixels_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    board.write_register(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = CFG_DATA_W'($urandom);
  endtask

  // Stop pushing, wait for every predicted result, then let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (board.expected_best.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reconfigure only once the block is quiet.
  task automatic configure(int unsigned rows_v, int unsigned cols_v, int unsigned win_v,
                           bit spare);
    drain();
    if (spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows_v));
    write_reg(REG_COL_COUNT, CFG_DATA_W'(cols_v));
    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(win_v));
  endtask

  // Stream count pixels, the final one flagged as last.
  task automatic send_image(int unsigned count, int unsigned density);
    for (int unsigned n = 0; n < count; n++) begin
      if (!push_steady) idle_cycles(gap_len());
      send_pixel($urandom_range(0, 99) < density, n == count - 1);
    end
    images_sent++;
  endtask

  // Result side: pop in stretches; each stretch either stalls at random or
  // takes every result at once.
  initial begin : pop_side
    int unsigned hold, stretch;
    bit          steady;
    hold    = 0;
    stretch = 0;
    steady  = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        steady  = ($urandom_range(0, 3) == 0);
        stretch = $urandom_range(50, 400);
      end
      stretch--;
      if (hold != 0) begin
        pop = 1'b0;
        hold--;
      end else begin
        pop = 1'b1;
        if (!steady) hold = gap_len();
      end
    end
  end

  initial begin : stimulus
    int unsigned pick, shape, rows_v, cols_v, win_v, lim, frame, count, image_idx;
    bit          special;
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a short image at the reset geometry, ended early, so no window
    // completes and the corner stays at the origin.
    send_image(3, 100);
    // Smallest legal image and window, solid: one window, count one.
    configure(3, 3, 3, 1'b0);
    send_image(9, 100);
    // Out-of-range sizes saturate to 3x3, and the window is wider than the
    // image; a write to the spare index must be ignored along the way.
    configure(2, 0, 9, 1'b1);
    send_image(9, 100);

    // Random images. Most are small and well formed; some end early, some
    // overrun and wrap, and a few stretch the geometry to its limits.
    image_idx = 0;
    special   = 1'b1;
    while (pixels_sent < PIXEL_TARGET || images_sent < IMAGE_FLOOR) begin
      pick        = $urandom_range(0, 99);
      push_steady = ($urandom_range(0, 3) == 0);
      if (image_idx == 3) begin
        // Largest window, written either exactly or above the cap; dense pixels
        // push the count past 512.
        rows_v = $urandom_range(32, 34);
        cols_v = $urandom_range(32, 34);
        win_v  = $urandom_range(0, 1) ? 32 : $urandom_range(33, 63);
        configure(rows_v, cols_v, win_v | ($urandom_range(0, 3) << 6), 1'b0);
        send_image(board.frame_pixels(), $urandom_range(80, 100));
        special = 1'b1;
      end else if (pick < 6) begin
        // Tall or wide strip at the full dimension, sparse so the best corner
        // can land far from the origin.
        if (pick < 3) begin
          rows_v = $urandom_range(128, 255);
          cols_v = $urandom_range(3, 4);
        end else begin
          rows_v = $urandom_range(3, 4);
          cols_v = $urandom_range(128, 255);
        end
        configure(rows_v, cols_v, $urandom_range(3, 4), 1'($urandom_range(0, 1)));
        send_image(board.frame_pixels(), $urandom_range(1, 5));
        special = 1'b1;
      end else begin
        // Keep the previous geometry now and then, so images run back to back.
        if (special || $urandom_range(0, 9) < 7) begin
          rows_v = small_dim();
          cols_v = small_dim();
          lim    = (rows_v < cols_v) ? rows_v : cols_v;
          if (lim < 3) lim = 3;
          shape  = $urandom_range(0, 99);
          if (shape < 85)      win_v = $urandom_range(3, lim);
          else if (shape < 95) win_v = $urandom_range(lim + 1, lim + 3);
          else                 win_v = $urandom_range(0, 2);
          configure(rows_v, cols_v, win_v | ($urandom_range(0, 3) << 6),
                    $urandom_range(0, 9) == 0);
        end
        frame = board.frame_pixels();
        shape = $urandom_range(0, 99);
        if (shape < 75)      count = frame;
        else if (shape < 87) count = $urandom_range(1, frame - 1);
        else                 count = $urandom_range(frame + 1, 2 * frame);
        send_image(count, pick_density());
        special = 1'b0;
      end
      image_idx++;
    end

    drain();
    $display("Sent %0d pixels in %0d images across saturated, oversized and wrapping geometries.",
             pixels_sent, images_sent);
    $display("Checked %0d results; largest interior count predicted %0d.",
             board.results_checked, board.peak_count);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/wicm_pkg.sv
rtl/wicm_front.sv
rtl/wicm_fifo.sv
rtl/wicm_back.sv
rtl/window_interior_count_max.sv
rtl/wicm_checker.sv
tb/sv/wicm_best_board_pkg.sv
tb/sv/testbench.sv
